// ===== src/tad_pkg.sv =====
// shared types and defaults for the triaxial average delta unit
// no dependencies
package tad_pkg;

  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned MaxWindowDef  = 255;
  localparam int unsigned CfgW          = 8;
  localparam logic [CfgW-1:0] CfgReset  = 8'd1;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_DONE
  } tad_state_e;

  typedef struct packed {
    logic add;
    logic load;
    logic step;
    logic commit;
  } tad_lane_ctl_t;

endpackage

// ===== src/tad_if.sv =====
// valid/ready channel interfaces for sample sets and results
// depends on tad_pkg
interface tad_in_if import tad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

interface tad_out_if import tad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_BITS-1:0]  avg_x;
  logic [SAMPLE_BITS-1:0]  avg_y;
  logic [SAMPLE_BITS-1:0]  avg_z;
  logic signed [SAMPLE_BITS:0] delta_x;
  logic signed [SAMPLE_BITS:0] delta_y;
  logic signed [SAMPLE_BITS:0] delta_z;

  modport source (output valid, output avg_x, output avg_y, output avg_z,
                  output delta_x, output delta_y, output delta_z, input ready);
  modport sink (input valid, input avg_x, input avg_y, input avg_z,
                input delta_x, input delta_y, input delta_z, output ready);
endinterface

// ===== src/triaxial_average_delta_unit.sv =====
// top level of the triaxial average delta unit: window control, three lanes, result register
// depends on tad_pkg, tad_if and tad_lane
//
// usage
//   smp_i carries one x/y/z sample set per transaction (valid/ready). the first set of
//   each window is a settling read and is dropped; the next sample_count sets are summed.
//   res_o carries one transaction per window: the truncated averages and their signed
//   deltas from the previous window's averages.
//   cfg_we_i/cfg_data_i write sample_count (zero ignored, saturated to MAX_WINDOW);
//   write only while idle.
// timing
//   the set that closes a window starts the three lane dividers, which retire one quotient
//   bit per cycle; the quotient is SAMPLE_BITS + clog2(largest window + 1) bits wide, 18 at
//   default size. the result register then loads once it is free. smp_i is not ready during
//   that time.
// reset
//   sums, window position and previous averages clear, sample_count becomes 1.
// backpressure
//   the result register holds while res_o.ready is low; the next window fills and divides
//   meanwhile, then waits with smp_i not ready until the register frees.
module triaxial_average_delta_unit import tad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned MAX_WINDOW  = MaxWindowDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  tad_in_if.sink          smp_i,
  tad_out_if.source       res_o
);

  localparam int unsigned WinMax = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
  localparam int unsigned CntW   = $clog2(WinMax + 1);
  localparam int unsigned SumW   = SAMPLE_BITS + CntW;
  localparam int unsigned StepW  = $clog2(SumW);

  tad_state_e      state_q, state_d;
  logic [CfgW-1:0] cnt_cfg_q, cnt_cfg_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] div_n_q, div_n_d;
  logic [StepW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;
  tad_lane_ctl_t   ctl;
  logic            smp_fire;

  logic [SAMPLE_BITS-1:0]      avg_x, avg_y, avg_z;
  logic signed [SAMPLE_BITS:0] delta_x, delta_y, delta_z;

  logic [SAMPLE_BITS-1:0]      avg_x_q, avg_y_q, avg_z_q;
  logic signed [SAMPLE_BITS:0] delta_x_q, delta_y_q, delta_z_q;

  // sample count register
  always_comb begin
    cnt_cfg_d = cnt_cfg_q;
    if (cfg_we_i && (cfg_data_i != '0)) begin
      if (32'(cfg_data_i) > 32'(MAX_WINDOW)) begin
        cnt_cfg_d = CfgW'(MAX_WINDOW);
      end else begin
        cnt_cfg_d = cfg_data_i;
      end
    end
  end

  assign smp_i.ready = (state_q == ST_ACC);
  assign smp_fire    = smp_i.valid && smp_i.ready;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    div_n_d     = div_n_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !res_o.ready;
    ctl         = '0;
    unique case (state_q)
      ST_ACC: begin
        if (smp_fire) begin
          if (pos_q == '0) begin
            pos_d = CntW'(1);
          end else if (32'(pos_q) < 32'(cnt_cfg_q)) begin
            ctl.add = 1'b1;
            pos_d   = pos_q + CntW'(1);
          end else begin
            ctl.load = 1'b1;
            div_n_d  = pos_q;
            pos_d    = '0;
            step_d   = '0;
            state_d  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        step_d   = step_q + StepW'(1);
        if (step_q == StepW'(SumW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          ctl.commit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cnt_cfg_q   <= CfgReset;
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_cfg_q   <= cnt_cfg_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_n_q <= div_n_d;
    if (ctl.commit) begin
      avg_x_q   <= avg_x;
      avg_y_q   <= avg_y;
      avg_z_q   <= avg_z;
      delta_x_q <= delta_x;
      delta_y_q <= delta_y;
      delta_z_q <= delta_z;
    end
  end

  tad_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (smp_i.sample_x),
    .div_n_i  (div_n_q),
    .avg_o    (avg_x),
    .delta_o  (delta_x)
  );

  tad_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (smp_i.sample_y),
    .div_n_i  (div_n_q),
    .avg_o    (avg_y),
    .delta_o  (delta_y)
  );

  tad_lane #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (smp_i.sample_z),
    .div_n_i  (div_n_q),
    .avg_o    (avg_z),
    .delta_o  (delta_z)
  );

  assign res_o.valid   = out_valid_q;
  assign res_o.avg_x   = avg_x_q;
  assign res_o.avg_y   = avg_y_q;
  assign res_o.avg_z   = avg_z_q;
  assign res_o.delta_x = delta_x_q;
  assign res_o.delta_y = delta_y_q;
  assign res_o.delta_z = delta_z_q;

`ifndef NO_ASSERTIONS
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= WinMax)
    else $error("window position beyond largest window");

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (32'(step_q) < SumW))
    else $error("divider step count overran");

  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside of divider completion");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_n_q != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

// ===== src/tad_lane.sv =====
// one axis lane: running sum, serial restoring divider, previous average and delta
// depends on tad_pkg
module tad_lane import tad_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned MAX_WINDOW  = MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tad_lane_ctl_t               ctl_i,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [$clog2(((MAX_WINDOW < 255) ? MAX_WINDOW : 255) + 1)-1:0] div_n_i,
  output logic [SAMPLE_BITS-1:0]      avg_o,
  output logic signed [SAMPLE_BITS:0] delta_o
);

  localparam int unsigned WinMax = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
  localparam int unsigned CntW   = $clog2(WinMax + 1);
  localparam int unsigned SumW   = SAMPLE_BITS + CntW;

  logic [SumW-1:0]        sum_q, sum_d;
  logic [SumW-1:0]        quo_q, quo_d;
  logic [CntW-1:0]        rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [SumW-1:0]        sum_in;
  logic [CntW:0]          rem_shift;
  logic                   fits;

  assign sum_in    = sum_q + SumW'(sample_i);
  assign rem_shift = {rem_q, quo_q[SumW-1]};
  assign fits      = rem_shift >= {1'b0, div_n_i};

  always_comb begin
    sum_d  = sum_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    prev_d = prev_q;
    if (ctl_i.add) begin
      sum_d = sum_in;
    end
    if (ctl_i.load) begin
      sum_d = '0;
      quo_d = sum_in;
      rem_d = '0;
    end
    if (ctl_i.step) begin
      quo_d = {quo_q[SumW-2:0], fits};
      rem_d = fits ? CntW'(rem_shift - {1'b0, div_n_i}) : rem_shift[CntW-1:0];
    end
    if (ctl_i.commit) begin
      prev_d = avg_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      sum_q  <= sum_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign avg_o   = quo_q[SAMPLE_BITS-1:0];
  assign delta_o = $signed({1'b0, avg_o} - {1'b0, prev_q});

endmodule

// ===== dv/tad_avg_scoreboard.sv =====
`timescale 1ns / 1ps
// scoreboard for the triaxial average delta unit: predicts each window result
// from accepted sample sets and length writes, compares it with the result channel
// depends on tad_pkg and tad_if
module tad_avg_scoreboard import tad_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  tad_in_if               smp_i,
  tad_out_if              res_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     windows_o
);

  localparam int unsigned SB = SampleBitsDef;

  typedef logic [SB-1:0]      sample_t;
  typedef logic signed [SB:0] delta_t;

  typedef struct packed {
    sample_t avg_x;
    sample_t avg_y;
    sample_t avg_z;
    delta_t  delta_x;
    delta_t  delta_y;
    delta_t  delta_z;
  } window_avg_t;

  window_avg_t avg_queue[$];
  int unsigned win_len;
  int unsigned win_pos;
  int unsigned sum_x, sum_y, sum_z;
  sample_t     prev_x, prev_y, prev_z;

  function automatic delta_t mean_step(sample_t now, sample_t last);
    return delta_t'({1'b0, now} - {1'b0, last});
  endfunction

  function void fold_sample_set(sample_t x, sample_t y, sample_t z);
    window_avg_t w;
    // settling set is dropped
    if (win_pos == 0) begin
      win_pos = 1;
      return;
    end
    sum_x += 32'(x);
    sum_y += 32'(y);
    sum_z += 32'(z);
    if (win_pos < win_len) begin
      win_pos++;
      return;
    end
    // divisor is the number of sets actually summed
    w.avg_x   = sample_t'(sum_x / win_pos);
    w.avg_y   = sample_t'(sum_y / win_pos);
    w.avg_z   = sample_t'(sum_z / win_pos);
    w.delta_x = mean_step(w.avg_x, prev_x);
    w.delta_y = mean_step(w.avg_y, prev_y);
    w.delta_z = mean_step(w.avg_z, prev_z);
    prev_x  = w.avg_x;
    prev_y  = w.avg_y;
    prev_z  = w.avg_z;
    sum_x   = 0;
    sum_y   = 0;
    sum_z   = 0;
    win_pos = 0;
    avg_queue.push_back(w);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    window_avg_t got, want;
    if (!rst_ni) begin
      win_len      = 32'(CfgReset);
      win_pos      = 0;
      sum_x        = 0;
      sum_y        = 0;
      sum_z        = 0;
      prev_x       = '0;
      prev_y       = '0;
      prev_z       = '0;
      avg_queue.delete();
      fail_count_o = 0;
      windows_o    = 0;
    end else begin
      // zero is ignored, larger values saturate
      if (cfg_we_i && cfg_data_i != '0) begin
        win_len = (32'(cfg_data_i) > MaxWindowDef) ? MaxWindowDef : 32'(cfg_data_i);
      end
      if (smp_i.valid && smp_i.ready) begin
        fold_sample_set(smp_i.sample_x, smp_i.sample_y, smp_i.sample_z);
      end
      if (res_i.valid && res_i.ready) begin
        got = {res_i.avg_x, res_i.avg_y, res_i.avg_z,
               res_i.delta_x, res_i.delta_y, res_i.delta_z};
        if (avg_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result transaction with none expected: avg %0d %0d %0d delta %0d %0d %0d",
                     $realtime, got.avg_x, got.avg_y, got.avg_z,
                     got.delta_x, got.delta_y, got.delta_z);
          end
        end else begin
          want = avg_queue.pop_front();
          windows_o++;
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: window %0d expected avg %0d %0d %0d delta %0d %0d %0d",
                       $realtime, windows_o, want.avg_x, want.avg_y, want.avg_z,
                       want.delta_x, want.delta_y, want.delta_z);
              $display("%0t: window %0d actual   avg %0d %0d %0d delta %0d %0d %0d",
                       $realtime, windows_o, got.avg_x, got.avg_y, got.avg_z,
                       got.delta_x, got.delta_y, got.delta_z);
            end
          end
        end
      end
    end
    pending_o = avg_queue.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// top of the triaxial average delta unit testbench: clock, reset, sample and
// length stimulus, result back-pressure, watchdog and verdict
// depends on tad_pkg, tad_if, the unit and tad_avg_scoreboard
module testbench;
  import tad_pkg::*;

  localparam int unsigned SB           = SampleBitsDef;
  localparam logic [SB-1:0] SampleMax  = '1;
  localparam int unsigned ItemTarget   = 1350;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned LongHold     = 800;
  localparam int unsigned IdleLimit    = 5000;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC
  } ready_mode_e;

  typedef enum int unsigned {
    VAL_UNIFORM,
    VAL_EXTREME,
    VAL_HIGH,
    VAL_LOW
  } val_mode_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned windows;
  int unsigned sets_sent     = 0;
  int unsigned cfg_writes    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned idle_cycles   = 0;

  tad_in_if  smp ();
  tad_out_if res ();

  triaxial_average_delta_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .smp_i      (smp),
    .res_o      (res)
  );

  tad_avg_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .smp_i        (smp),
    .res_i        (res),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .windows_o    (windows)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // no transaction on either channel for too long
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("triaxial_average_delta_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stall patterns, plus long hold-offs on request
  initial begin
    int unsigned holds_done, pat_left, period, phase;
    ready_mode_e mode;
    res.ready  = 1'b0;
    holds_done = 0;
    pat_left   = 0;
    period     = 2;
    phase      = 0;
    mode       = RDY_ALWAYS;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        res.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else begin
        if (pat_left == 0) begin
          mode     = ready_mode_e'($urandom_range(RDY_ALWAYS, RDY_PERIODIC));
          period   = $urandom_range(2, 9);
          pat_left = $urandom_range(16, 160);
          phase    = 0;
        end
        pat_left--;
        phase++;
        case (mode)
          RDY_ALWAYS: res.ready <= 1'b1;
          RDY_COIN:   res.ready <= ($urandom_range(0, 3) != 0);
          default:    res.ready <= ((phase % period) != 0);
        endcase
      end
    end
  end

  function automatic logic [SB-1:0] pick_sample(val_mode_e m);
    case (m)
      VAL_UNIFORM: return SB'($urandom_range(0, SampleMax));
      VAL_EXTREME: return ($urandom_range(0, 1) != 0) ? SampleMax : '0;
      VAL_HIGH:    return SampleMax - SB'($urandom_range(0, 23));
      default:     return SB'($urandom_range(0, 23));
    endcase
  endfunction

  task automatic send_set(input logic [SB-1:0] x, input logic [SB-1:0] y,
                          input logic [SB-1:0] z);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        @(negedge clk_i);
        smp.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    smp.valid    <= 1'b1;
    smp.sample_x <= x;
    smp.sample_y <= y;
    smp.sample_z <= z;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    sets_sent++;
  endtask

  task automatic send_random(input val_mode_e m);
    send_set(pick_sample(m), pick_sample(m), pick_sample(m));
  endtask

  // stop offering and let every expected window come out
  task automatic go_idle;
    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_len(input logic [CfgW-1:0] v);
    go_idle();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int unsigned pick, len;
    logic [CfgW-1:0] wlen;
    val_mode_e vm;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    smp.valid    = 1'b0;
    smp.sample_x = '0;
    smp.sample_y = '0;
    smp.sample_z = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // window of one after reset, full-scale swings both ways
    send_set(SampleMax, SampleMax, SampleMax);
    send_set('0, '0, '0);
    send_set('0, '0, '0);
    send_set(SampleMax, SampleMax, SampleMax);
    send_set(SampleMax, SampleMax, SampleMax);
    send_set('0, '0, '0);
    send_set('0, '0, '0);
    send_set(10'h155, 10'h2aa, 10'h3ff);
    send_set('0, '0, '0);
    send_set(10'h2aa, 10'h155, 10'h000);

    // zero write leaves the length at one
    write_len('0);
    send_set(10'd1, 10'd2, 10'd3);
    send_set(10'h3ff, 10'h000, 10'h200);

    write_len(8'd3);
    repeat (4) send_set(SampleMax, SampleMax, SampleMax);

    // length shrinks below the sets already summed
    write_len(8'd6);
    repeat (5) send_random(VAL_UNIFORM);
    write_len(8'd2);
    send_random(VAL_UNIFORM);

    // longest window, largest sums
    write_len(8'hff);
    repeat (256) send_set(SampleMax, SampleMax, SampleMax);

    // result side holds off while sets keep coming
    write_len(8'd2);
    hold_requests++;
    repeat (40) send_random(VAL_UNIFORM);

    while (sets_sent < ItemTarget) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) wlen = '0;
      else if (pick == 1) wlen = 8'hff;
      else if (pick < 5) wlen = 8'd1;
      else if (pick < 17) wlen = CfgW'($urandom_range(2, 8));
      else wlen = CfgW'($urandom_range(9, 40));
      write_len(wlen);
      if (wlen == 8'hff) len = $urandom_range(1, 60);
      else len = $urandom_range(1, 6) * (32'(wlen) + 1) + $urandom_range(0, 32'(wlen));
      vm = val_mode_e'($urandom_range(VAL_UNIFORM, VAL_LOW));
      repeat (len) send_random(vm);
    end

    go_idle();
    $display("covered %0d sample sets and %0d checked windows across %0d length writes",
             sets_sent, windows, cfg_writes);
    $display("lengths from one to full scale, zero writes, shrinking mid-window, long stall");
    if (fail_count == 0) begin
      $display("triaxial_average_delta_unit test passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("triaxial_average_delta_unit test failed");
    end
    $finish;
  end

endmodule
